/* rtl/po_cmc_pkg.sv */
// Package for the gettext catalog message counter.
// Holds the line prefix tables, character codes and port widths.
// No dependencies.
package po_cmc_pkg;

  typedef logic [7:0] byte_t;

  localparam int NUM_PFX  = 5;
  localparam int PFX_COLS = 7;

  localparam int P_MSGID  = 0;
  localparam int P_MSGSTR = 1;
  localparam int P_COMMA  = 2;
  localparam int P_OBS    = 3;
  localparam int P_QUOTE  = 4;

  localparam byte_t CH_NL     = 8'd10;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LBRACK = 8'h5B;
  localparam byte_t CH_Y      = 8'h79;

  localparam logic [31:0] FUZZ_WORD = 32'h66757A7A;

  localparam byte_t PFX_TEXT [NUM_PFX][PFX_COLS] = '{
    '{8'h6D, 8'h73, 8'h67, 8'h69, 8'h64, 8'h20, 8'h22},
    '{8'h6D, 8'h73, 8'h67, 8'h73, 8'h74, 8'h72, 8'h00},
    '{8'h23, 8'h2C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] PFX_LEN [NUM_PFX] = '{3'd7, 3'd6, 3'd2, 3'd2, 3'd1};

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 32;
  localparam int OUT_TDATA_W = 4 * OUT_FIELD_W;

endpackage

/* rtl/po_catalog_message_counter.sv */
// Top level of the gettext catalog message counter.
// Instantiates po_cmc_line_scan and po_cmc_result; uses po_cmc_pkg.
//
//   channel  dir  tdata fields (low bit up)                       tuser/tlast
//   in_      in   text_byte[7:0]                                  tlast = stream_end
//   out_     out  message_total, untranslated_total,              none
//                 fuzzy_total, translated_total (32 bits each)
//
// One byte is taken per cycle while the input is not held (see below). After the final
// byte is accepted, the counts pass the snapshot register, then the result register.
// Reset (rst_n low, synchronous) clears the line state and counters.
// A stalled result holds the result register while the snapshot takes the next
// final counts; only a final byte that finds both full waits and holds the input.
module po_catalog_message_counter #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [po_cmc_pkg::IN_TDATA_W-1:0]   in_tdata,   // text_byte[7:0]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // message_total[31:0], untranslated_total[63:32], fuzzy_total[95:64],
  // translated_total[127:96]
  output logic [po_cmc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                  snap_valid;
  logic                  snap_ready;
  logic [COUNT_BITS-1:0] snap_msg;
  logic [COUNT_BITS-1:0] snap_unt;
  logic [COUNT_BITS-1:0] snap_fz;

  po_cmc_line_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_msg   (snap_msg),
    .snap_unt   (snap_unt),
    .snap_fz    (snap_fz)
  );

  po_cmc_result #(
    .COUNT_BITS (COUNT_BITS)
  ) u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_msg   (snap_msg),
    .snap_unt   (snap_unt),
    .snap_fz    (snap_fz),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/po_cmc_line_scan.sv */
// Input register, per-byte line tracking and the three running counters.
// Emits a registered snapshot of the final counts on the last byte.
// Depends on po_cmc_pkg.
module po_cmc_line_scan #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [po_cmc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                                in_tlast,
  output logic                                snap_valid,
  input  logic                                snap_ready,
  output logic [COUNT_BITS-1:0]               snap_msg,
  output logic [COUNT_BITS-1:0]               snap_unt,
  output logic [COUNT_BITS-1:0]               snap_fz
);

  logic                       in_v_r, in_v_nxt;
  po_cmc_pkg::byte_t          in_byte_r;
  logic                       in_last_r;
  logic                       consume;

  logic [2:0]                 col_r, col_nxt;
  logic [po_cmc_pkg::NUM_PFX-1:0] pfx_r, pfx_nxt;
  logic [23:0]                tail_r, tail_nxt;
  logic [31:0]                win_r, win_nxt;
  logic                       fuzzy_r, fuzzy_nxt;
  logic                       plural_r, plural_nxt;
  logic                       pu_r, pu_nxt;
  logic                       pf_r, pf_nxt;
  logic                       pp_r, pp_nxt;
  logic                       skip_r, skip_nxt;
  logic [COUNT_BITS-1:0]      msg_r, msg_nxt;
  logic [COUNT_BITS-1:0]      unt_r, unt_nxt;
  logic [COUNT_BITS-1:0]      fz_r, fz_nxt;

  logic                       snap_v_r, snap_v_nxt;
  logic [COUNT_BITS-1:0]      snap_msg_r, snap_unt_r, snap_fz_r;

  logic [po_cmc_pkg::NUM_PFX-1:0] starts;
  logic                       inc_m;
  logic [1:0]                 inc_u, inc_f;
  logic                       cont;
  logic [COUNT_BITS-1:0]      msg_sum, unt_sum, fz_sum;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
                                                    input logic [1:0] inc);
    logic [COUNT_BITS:0] s;
    s = {1'b0, v} + {{(COUNT_BITS-1){1'b0}}, inc};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  assign consume   = in_v_r && (!in_last_r || !snap_v_r || snap_ready);
  assign in_tready = !in_v_r || consume;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (consume) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    for (int p = 0; p < po_cmc_pkg::NUM_PFX; p++) begin
      starts[p] = pfx_r[p] && (col_r >= po_cmc_pkg::PFX_LEN[p]);
    end
  end

  always_comb begin
    col_nxt    = col_r;
    pfx_nxt    = pfx_r;
    tail_nxt   = tail_r;
    win_nxt    = win_r;
    fuzzy_nxt  = fuzzy_r;
    plural_nxt = plural_r;
    pu_nxt     = pu_r;
    pf_nxt     = pf_r;
    pp_nxt     = pp_r;
    skip_nxt   = skip_r;
    inc_m      = 1'b0;
    inc_u      = 2'd0;
    inc_f      = 2'd0;
    cont       = 1'b1;

    if (in_byte_r == po_cmc_pkg::CH_NL) begin
      if (skip_r) begin
        if (starts[po_cmc_pkg::P_MSGSTR] || starts[po_cmc_pkg::P_QUOTE]) begin
          cont = 1'b0;
        end else begin
          skip_nxt = 1'b0;
        end
      end else if (pu_r) begin
        pu_nxt = 1'b0;
        if (!starts[po_cmc_pkg::P_QUOTE]) begin
          inc_u = 2'd1;
        end
        if (pp_r) begin
          pp_nxt   = 1'b0;
          skip_nxt = 1'b1;
          cont     = 1'b0;
        end
      end
      if (cont) begin
        if (pf_r) begin
          pf_nxt = 1'b0;
          if (!starts[po_cmc_pkg::P_OBS]) begin
            inc_f = 2'd1;
          end
        end
        if (starts[po_cmc_pkg::P_MSGID]) begin
          inc_m = 1'b1;
        end else if (starts[po_cmc_pkg::P_COMMA]) begin
          if (fuzzy_r) begin
            pf_nxt = 1'b1;
          end
        end else if (starts[po_cmc_pkg::P_MSGSTR]) begin
          if (tail_r[7:0] == po_cmc_pkg::CH_QUOTE && tail_r[15:8] == po_cmc_pkg::CH_QUOTE &&
              tail_r[23:16] != po_cmc_pkg::CH_BSLASH) begin
            pu_nxt = 1'b1;
            if (plural_r) begin
              pp_nxt = 1'b1;
            end
          end
        end
      end
      col_nxt    = 3'd0;
      pfx_nxt    = '1;
      tail_nxt   = '0;
      win_nxt    = '0;
      fuzzy_nxt  = 1'b0;
      plural_nxt = 1'b0;
    end else begin
      if (col_r != 3'd7) begin
        for (int p = 0; p < po_cmc_pkg::NUM_PFX; p++) begin
          if (col_r < po_cmc_pkg::PFX_LEN[p] &&
              in_byte_r != po_cmc_pkg::PFX_TEXT[p][col_r]) begin
            pfx_nxt[p] = 1'b0;
          end
        end
        if (col_r == 3'd6) begin
          plural_nxt = (in_byte_r == po_cmc_pkg::CH_LBRACK);
        end
        col_nxt = col_r + 3'd1;
      end
      if (win_r == po_cmc_pkg::FUZZ_WORD && in_byte_r == po_cmc_pkg::CH_Y) begin
        fuzzy_nxt = 1'b1;
      end
      win_nxt  = {win_r[23:0], in_byte_r};
      tail_nxt = {tail_r[15:0], in_byte_r};
    end

    if (in_last_r) begin
      inc_u = inc_u + {1'b0, pu_nxt};
      inc_f = inc_f + {1'b0, pf_nxt};
    end

    msg_sum = sat_add(msg_r, {1'b0, inc_m});
    unt_sum = sat_add(unt_r, inc_u);
    fz_sum  = sat_add(fz_r, inc_f);
    msg_nxt = msg_sum;
    unt_nxt = unt_sum;
    fz_nxt  = fz_sum;

    if (in_last_r) begin
      col_nxt    = 3'd0;
      pfx_nxt    = '1;
      tail_nxt   = '0;
      win_nxt    = '0;
      fuzzy_nxt  = 1'b0;
      plural_nxt = 1'b0;
      pu_nxt     = 1'b0;
      pf_nxt     = 1'b0;
      pp_nxt     = 1'b0;
      skip_nxt   = 1'b0;
      msg_nxt    = '0;
      unt_nxt    = '0;
      fz_nxt     = '0;
    end
  end

  assign snap_v_nxt = (snap_v_r && !snap_ready) || (consume && in_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      snap_v_r <= 1'b0;
      col_r    <= 3'd0;
      pfx_r    <= '1;
      tail_r   <= '0;
      win_r    <= '0;
      fuzzy_r  <= 1'b0;
      plural_r <= 1'b0;
      pu_r     <= 1'b0;
      pf_r     <= 1'b0;
      pp_r     <= 1'b0;
      skip_r   <= 1'b0;
      msg_r    <= '0;
      unt_r    <= '0;
      fz_r     <= '0;
    end else begin
      in_v_r   <= in_v_nxt;
      snap_v_r <= snap_v_nxt;
      if (consume) begin
        col_r    <= col_nxt;
        pfx_r    <= pfx_nxt;
        tail_r   <= tail_nxt;
        win_r    <= win_nxt;
        fuzzy_r  <= fuzzy_nxt;
        plural_r <= plural_nxt;
        pu_r     <= pu_nxt;
        pf_r     <= pf_nxt;
        pp_r     <= pp_nxt;
        skip_r   <= skip_nxt;
        msg_r    <= msg_nxt;
        unt_r    <= unt_nxt;
        fz_r     <= fz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (consume && in_last_r) begin
      snap_msg_r <= msg_sum;
      snap_unt_r <= unt_sum;
      snap_fz_r  <= fz_sum;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap_msg   = snap_msg_r;
  assign snap_unt   = snap_unt_r;
  assign snap_fz    = snap_fz_r;

endmodule

/* rtl/po_cmc_result.sv */
// Result stage: clamps the final counts to 32 bits, forms the translated
// total and holds the result request. Depends on po_cmc_pkg.
module po_cmc_result #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                snap_valid,
  output logic                                snap_ready,
  input  logic [COUNT_BITS-1:0]               snap_msg,
  input  logic [COUNT_BITS-1:0]               snap_unt,
  input  logic [COUNT_BITS-1:0]               snap_fz,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [po_cmc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                                out_v_r, out_v_nxt;
  logic [po_cmc_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic [COUNT_BITS:0]                 used;
  logic [COUNT_BITS-1:0]               diff;

  function automatic logic [po_cmc_pkg::OUT_FIELD_W-1:0] clamp32(
      input logic [COUNT_BITS-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (|ext[63:32]) ? {po_cmc_pkg::OUT_FIELD_W{1'b1}} : ext[31:0];
  endfunction

  assign snap_ready = !out_v_r || out_tready;

  always_comb begin
    used = {1'b0, snap_unt} + {1'b0, snap_fz};
    diff = '0;
    if (used < {1'b0, snap_msg}) begin
      diff = snap_msg - used[COUNT_BITS-1:0];
    end
    out_data_nxt = {clamp32(diff), clamp32(snap_fz), clamp32(snap_unt), clamp32(snap_msg)};
    out_v_nxt    = (out_v_r && !out_tready) || snap_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
